// ===== sv/lru_k_replacement_policy_unit_defines.svh =====
// ----------------------------------------------------------------------------
// LRU-K replacement policy unit: assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LRU_K_REPLACEMENT_POLICY_UNIT_DEFINES_SVH
`define LRU_K_REPLACEMENT_POLICY_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define LRUK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define LRUK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LRUK_ASSERT(lbl, prop, msg)
`define LRUK_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/lruk_pkg.sv =====
// ----------------------------------------------------------------------------
// lruk_pkg
// Shared constants of the LRU-K replacement policy unit.
// ----------------------------------------------------------------------------
package lruk_pkg;

  // Default storage sizes.
  localparam int HIST_DEPTH_DEF  = 16;
  localparam int CACHE_DEPTH_DEF = 8;
  localparam int KEY_BITS_DEF    = 32;

  // Width of the key fields on the ports.
  localparam int PORT_KEY_W = 32;

  // Configuration port.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Configuration register widths.
  localparam int KTH_W  = 4;
  localparam int HLIM_W = 5;
  localparam int CLIM_W = 4;

  // Configuration register reset values.
  localparam logic [KTH_W-1:0]  KTH_RST  = 4'd2;
  localparam logic [HLIM_W-1:0] HLIM_RST = 5'd16;
  localparam logic [CLIM_W-1:0] CLIM_RST = 4'd8;

  // Register indexes (word address paddr[3:2]).
  localparam logic [1:0] REG_K_THRESHOLD   = 2'd0;
  localparam logic [1:0] REG_HISTORY_LIMIT = 2'd1;
  localparam logic [1:0] REG_CACHE_LIMIT   = 2'd2;

endpackage

// ===== sv/lru_k_replacement_policy_unit.sv =====
// ----------------------------------------------------------------------------
// lru_k_replacement_policy_unit
// LRU-K cache replacement policy: a key enters the LRU cache on an access that
// finds at least K - 1 earlier accesses of it recorded in a history FIFO.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                      Payload
//  --------  ---------  -----------------------------  -------------------------
//  access    in         access_valid_i/access_ready_o  access_key_i
//  result    out        result_valid_o/result_ready_i  hit, promoted, evict, drop
//  config    in         psel/penable/pwrite, pready=1  paddr, pwdata, prdata
//
//  Every request walks the cache key store. A miss then walks the history
//  store, and a promotion walks it once more to compact it. Each key store
//  has a single read port, which is walked one entry per cycle.
//  A new request is taken while the previous result still waits; the final
//  step then holds until the result register is free.
//  Reset clears the control state and the configuration; the key stores are
//  not cleared, since only entries below the fill count or marked valid are used.
//
module lru_k_replacement_policy_unit
  import lruk_pkg::*;
#(
  parameter int HIST_DEPTH  = HIST_DEPTH_DEF,
  parameter int CACHE_DEPTH = CACHE_DEPTH_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Access requests.
  input  logic                  access_valid_i,
  output logic                  access_ready_o,
  input  logic [PORT_KEY_W-1:0] access_key_i,
  // Results.
  output logic                  result_valid_o,
  input  logic                  result_ready_i,
  output logic                  hit_o,
  output logic                  promoted_o,
  output logic                  cache_evict_valid_o,
  output logic [PORT_KEY_W-1:0] cache_evict_key_o,
  output logic                  history_drop_valid_o,
  output logic [PORT_KEY_W-1:0] history_drop_key_o
);

  // History index/count widths and cache slot/count widths.
  localparam int HIW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int HCW = $clog2(HIST_DEPTH + 1);
  localparam int CIW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CCW = $clog2(CACHE_DEPTH + 1);
  localparam int SCW = (HCW > CCW) ? HCW : CCW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CSCAN,
    ST_HSCAN,
    ST_HCOMP,
    ST_FINISH
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [KTH_W-1:0]  kth_q;
  logic [HLIM_W-1:0] hlim_q;
  logic [CLIM_W-1:0] clim_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kth_q  <= KTH_RST;
      hlim_q <= HLIM_RST;
      clim_q <= CLIM_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_K_THRESHOLD:   kth_q  <= pwdata[KTH_W-1:0];
        REG_HISTORY_LIMIT: hlim_q <= pwdata[HLIM_W-1:0];
        REG_CACHE_LIMIT:   clim_q <= pwdata[CLIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_K_THRESHOLD:   prdata = APB_DATA_W'(kth_q);
      REG_HISTORY_LIMIT: prdata = APB_DATA_W'(hlim_q);
      REG_CACHE_LIMIT:   prdata = APB_DATA_W'(clim_q);
      default:           prdata = '0;
    endcase
  end

  // Effective thresholds: K below two acts as two, the limits are clamped to
  // one at the bottom and to the store depth at the top.
  logic [KTH_W-1:0] kth_eff;
  logic [HCW-1:0]   hlim_eff;
  logic [CCW-1:0]   clim_eff;

  always_comb begin
    kth_eff = (kth_q < KTH_W'(2)) ? KTH_W'(2) : kth_q;
    if (hlim_q == '0) begin
      hlim_eff = HCW'(1);
    end else if (32'(hlim_q) > 32'(HIST_DEPTH)) begin
      hlim_eff = HCW'(HIST_DEPTH);
    end else begin
      hlim_eff = HCW'(hlim_q);
    end
    if (clim_q == '0) begin
      clim_eff = CCW'(1);
    end else if (32'(clim_q) > 32'(CACHE_DEPTH)) begin
      clim_eff = CCW'(CACHE_DEPTH);
    end else begin
      clim_eff = CCW'(clim_q);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state.
  // --------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [SCW-1:0]      scan_q, scan_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic                chit_q, chit_d;
  logic [CIW-1:0]      hslot_q, hslot_d;
  logic                free_found_q, free_found_d;
  logic [CIW-1:0]      free_slot_q, free_slot_d;
  logic [KEY_BITS-1:0] evk_q, evk_d;
  logic [HCW-1:0]      seen_q, seen_d;
  logic [KEY_BITS-1:0] oldest_q, oldest_d;
  logic [HCW-1:0]      wr_q, wr_d;
  logic                prom_q, prom_d;

  // History FIFO bookkeeping (circular buffer) and cache bookkeeping.
  logic [HIW-1:0]         head_q, head_d;
  logic [HCW-1:0]         hcnt_q, hcnt_d;
  logic [CACHE_DEPTH-1:0] cvalid_q, cvalid_d;
  logic [CIW-1:0]         crank_q  [CACHE_DEPTH];
  logic [CIW-1:0]         crank_d  [CACHE_DEPTH];
  logic [CCW-1:0]         occ_q, occ_d;

  // Result register.
  logic                  res_valid_q, res_valid_d;
  logic                  res_hit_q, res_hit_d;
  logic                  res_prom_q, res_prom_d;
  logic                  res_ev_vld_q, res_ev_vld_d;
  logic [PORT_KEY_W-1:0] res_ev_key_q, res_ev_key_d;
  logic                  res_dr_vld_q, res_dr_vld_d;
  logic [PORT_KEY_W-1:0] res_dr_key_q, res_dr_key_d;

  // Key store ports.
  logic                hram_we;
  logic [HIW-1:0]      hram_waddr, hram_raddr;
  logic [KEY_BITS-1:0] hram_wdata, hram_rdata;
  logic                cram_we;
  logic [CIW-1:0]      cram_waddr, cram_raddr;
  logic [KEY_BITS-1:0] cram_wdata, cram_rdata;

  lruk_ram #(
    .DEPTH (HIST_DEPTH),
    .WIDTH (KEY_BITS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hram_we),
    .waddr_i (hram_waddr),
    .wdata_i (hram_wdata),
    .raddr_i (hram_raddr),
    .rdata_o (hram_rdata)
  );

  lruk_ram #(
    .DEPTH (CACHE_DEPTH),
    .WIDTH (KEY_BITS)
  ) u_cache_ram (
    .clk_i   (clk_i),
    .we_i    (cram_we),
    .waddr_i (cram_waddr),
    .wdata_i (cram_wdata),
    .raddr_i (cram_raddr),
    .rdata_o (cram_rdata)
  );

  // Physical history slot of a logical position counted from the oldest entry.
  // The offset never exceeds the depth, so one conditional subtract wraps it.
  function automatic logic [HIW-1:0] hist_addr(input logic [HIW-1:0] base,
                                               input logic [31:0]    ofs);
    logic [31:0] sum;
    sum = 32'(base) + ofs;
    if (sum >= 32'(HIST_DEPTH)) begin
      sum = sum - 32'(HIST_DEPTH);
    end
    return sum[HIW-1:0];
  endfunction

  // Keys are taken at KEY_BITS bits and reported at the port width.
  logic [63:0]         key_in_wide;
  logic [KEY_BITS-1:0] key_in;
  logic [63:0]         evk_wide;
  logic [63:0]         oldest_wide;

  assign key_in_wide = {32'd0, access_key_i};
  assign key_in      = key_in_wide[KEY_BITS-1:0];
  assign evk_wide    = 64'(evk_q);
  assign oldest_wide = 64'(oldest_q);

  // When the cache is at its limit, a promotion evicts every valid entry whose
  // rank is at or above limit - 1, the least recent ones. Ranks of valid
  // entries always form 0 .. occupancy - 1.
  logic                   need_evict;
  logic [CACHE_DEPTH-1:0] evict_mask;

  assign need_evict = (occ_q >= clim_eff);

  always_comb begin
    for (int j = 0; j < CACHE_DEPTH; j++) begin
      evict_mask[j] = need_evict && cvalid_q[j] &&
                      ((32'(crank_q[j]) + 32'd1) >= 32'(clim_eff));
    end
  end

  // Slot whose read data is present this cycle (one behind the scan counter).
  logic [SCW-1:0] scan_prev;
  logic [CIW-1:0] slot_s;

  assign scan_prev = scan_q - SCW'(1);
  assign slot_s    = scan_prev[CIW-1:0];

  // --------------------------------------------------------------------------
  // Next-state logic.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    key_d        = key_q;
    chit_d       = chit_q;
    hslot_d      = hslot_q;
    free_found_d = free_found_q;
    free_slot_d  = free_slot_q;
    evk_d        = evk_q;
    seen_d       = seen_q;
    oldest_d     = oldest_q;
    wr_d         = wr_q;
    prom_d       = prom_q;
    head_d       = head_q;
    hcnt_d       = hcnt_q;
    cvalid_d     = cvalid_q;
    crank_d      = crank_q;
    occ_d        = occ_q;

    res_valid_d  = res_valid_q;
    res_hit_d    = res_hit_q;
    res_prom_d   = res_prom_q;
    res_ev_vld_d = res_ev_vld_q;
    res_ev_key_d = res_ev_key_q;
    res_dr_vld_d = res_dr_vld_q;
    res_dr_key_d = res_dr_key_q;

    hram_we    = 1'b0;
    hram_waddr = '0;
    hram_wdata = key_q;
    hram_raddr = '0;
    cram_we    = 1'b0;
    cram_waddr = free_slot_q;
    cram_wdata = key_q;
    cram_raddr = '0;

    if (res_valid_q && result_ready_i) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (access_valid_i) begin
          key_d        = key_in;
          scan_d       = '0;
          chit_d       = 1'b0;
          free_found_d = 1'b0;
          seen_d       = '0;
          wr_d         = '0;
          prom_d       = 1'b0;
          state_d      = ST_CSCAN;
        end
      end

      // Walk every cache slot: look for the key, the first slot that will be
      // free after a promotion, and the least recent key.
      ST_CSCAN: begin
        if (scan_q < SCW'(CACHE_DEPTH)) begin
          cram_raddr = scan_q[CIW-1:0];
        end
        if (scan_q != '0) begin
          if (cvalid_q[slot_s] && (cram_rdata == key_q) && !chit_q) begin
            chit_d  = 1'b1;
            hslot_d = slot_s;
          end
          if (!free_found_q && (!cvalid_q[slot_s] || evict_mask[slot_s])) begin
            free_found_d = 1'b1;
            free_slot_d  = slot_s;
          end
          if (cvalid_q[slot_s] && ((32'(crank_q[slot_s]) + 32'd1) == 32'(occ_q))) begin
            evk_d = cram_rdata;
          end
        end
        if (scan_q == SCW'(CACHE_DEPTH)) begin
          scan_d  = '0;
          state_d = chit_d ? ST_FINISH : ST_HSCAN;
        end else begin
          scan_d = scan_q + SCW'(1);
        end
      end

      // Count the key's entries in the history and keep the oldest entry.
      ST_HSCAN: begin
        hram_raddr = hist_addr(head_q, 32'(scan_q));
        if (scan_q != '0) begin
          if (hram_rdata == key_q) begin
            seen_d = seen_q + HCW'(1);
          end
          if (scan_q == SCW'(1)) begin
            oldest_d = hram_rdata;
          end
        end
        if (scan_q == SCW'(hcnt_q)) begin
          scan_d = '0;
          if ((seen_d != '0) && ((32'(seen_d) + 32'd1) >= 32'(kth_eff))) begin
            prom_d  = 1'b1;
            state_d = ST_HCOMP;
          end else begin
            prom_d  = 1'b0;
            state_d = ST_FINISH;
          end
        end else begin
          scan_d = scan_q + SCW'(1);
        end
      end

      // Compact the history in place, dropping every entry of the key. The
      // write pointer never passes the read pointer, so no entry is lost.
      ST_HCOMP: begin
        hram_raddr = hist_addr(head_q, 32'(scan_q));
        if ((scan_q != '0) && (hram_rdata != key_q)) begin
          hram_we    = 1'b1;
          hram_waddr = hist_addr(head_q, 32'(wr_q));
          hram_wdata = hram_rdata;
          wr_d       = wr_q + HCW'(1);
        end
        if (scan_q == SCW'(hcnt_q)) begin
          scan_d  = '0;
          hcnt_d  = wr_d;
          state_d = ST_FINISH;
        end else begin
          scan_d = scan_q + SCW'(1);
        end
      end

      // Commit the bookkeeping and load the result register once it is free.
      ST_FINISH: begin
        if (!res_valid_q || result_ready_i) begin
          state_d      = ST_IDLE;
          res_valid_d  = 1'b1;
          res_hit_d    = 1'b0;
          res_prom_d   = 1'b0;
          res_ev_vld_d = 1'b0;
          res_ev_key_d = '0;
          res_dr_vld_d = 1'b0;
          res_dr_key_d = '0;
          if (chit_q) begin
            res_hit_d = 1'b1;
            for (int j = 0; j < CACHE_DEPTH; j++) begin
              if (cvalid_q[j] && (crank_q[j] < crank_q[hslot_q])) begin
                crank_d[j] = crank_q[j] + CIW'(1);
              end
            end
            crank_d[hslot_q] = '0;
          end else if (prom_q) begin
            res_prom_d = 1'b1;
            for (int j = 0; j < CACHE_DEPTH; j++) begin
              cvalid_d[j] = cvalid_q[j] && !evict_mask[j];
              if (cvalid_q[j] && !evict_mask[j]) begin
                crank_d[j] = crank_q[j] + CIW'(1);
              end
            end
            cvalid_d[free_slot_q] = 1'b1;
            crank_d[free_slot_q]  = '0;
            cram_we               = 1'b1;
            if (need_evict) begin
              res_ev_vld_d = 1'b1;
              res_ev_key_d = evk_wide[PORT_KEY_W-1:0];
              occ_d        = clim_eff;
            end else begin
              occ_d = occ_q + CCW'(1);
            end
          end else begin
            // The append slot is the old head plus the old count, whether or
            // not the oldest entries are dropped first.
            hram_we    = 1'b1;
            hram_waddr = hist_addr(head_q, 32'(hcnt_q));
            hram_wdata = key_q;
            if (hcnt_q >= hlim_eff) begin
              res_dr_vld_d = 1'b1;
              res_dr_key_d = oldest_wide[PORT_KEY_W-1:0];
              head_d       = hist_addr(head_q,
                                       32'(hcnt_q) - 32'(hlim_eff) + 32'd1);
              hcnt_d       = hlim_eff;
            end else begin
              hcnt_d = hcnt_q + HCW'(1);
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State and result registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      scan_q       <= '0;
      chit_q       <= 1'b0;
      free_found_q <= 1'b0;
      seen_q       <= '0;
      wr_q         <= '0;
      prom_q       <= 1'b0;
      head_q       <= '0;
      hcnt_q       <= '0;
      occ_q        <= '0;
      res_valid_q  <= 1'b0;
      res_hit_q    <= 1'b0;
      res_prom_q   <= 1'b0;
      res_ev_vld_q <= 1'b0;
      res_ev_key_q <= '0;
      res_dr_vld_q <= 1'b0;
      res_dr_key_q <= '0;
      cvalid_q     <= '0;
      for (int j = 0; j < CACHE_DEPTH; j++) begin
        crank_q[j] <= '0;
      end
    end else begin
      state_q      <= state_d;
      scan_q       <= scan_d;
      chit_q       <= chit_d;
      free_found_q <= free_found_d;
      seen_q       <= seen_d;
      wr_q         <= wr_d;
      prom_q       <= prom_d;
      head_q       <= head_d;
      hcnt_q       <= hcnt_d;
      occ_q        <= occ_d;
      res_valid_q  <= res_valid_d;
      res_hit_q    <= res_hit_d;
      res_prom_q   <= res_prom_d;
      res_ev_vld_q <= res_ev_vld_d;
      res_ev_key_q <= res_ev_key_d;
      res_dr_vld_q <= res_dr_vld_d;
      res_dr_key_q <= res_dr_key_d;
      cvalid_q     <= cvalid_d;
      crank_q      <= crank_d;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    hslot_q      <= hslot_d;
    free_slot_q  <= free_slot_d;
    evk_q        <= evk_d;
    oldest_q     <= oldest_d;
  end

  assign access_ready_o       = (state_q == ST_IDLE);
  assign result_valid_o       = res_valid_q;
  assign hit_o                = res_hit_q;
  assign promoted_o           = res_prom_q;
  assign cache_evict_valid_o  = res_ev_vld_q;
  assign cache_evict_key_o    = res_ev_key_q;
  assign history_drop_valid_o = res_dr_vld_q;
  assign history_drop_key_o   = res_dr_key_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
`include "lru_k_replacement_policy_unit_defines.svh"

  `LRUK_ASSERT(a_occ_matches_valid, $countones(cvalid_q) == 32'(occ_q), "cache occupancy out of step")
  `LRUK_ASSERT(a_hist_count_bound, hcnt_q <= HCW'(HIST_DEPTH), "history count above depth")
  `LRUK_ASSERT_NEXT(a_busy_after_accept, access_valid_i && access_ready_o, !access_ready_o, "ready right after accept")
  `LRUK_ASSERT(a_single_outcome, !(res_valid_q && res_hit_q && (res_prom_q || res_dr_vld_q)), "hit with other outcome")

endmodule

// ===== sv/lruk_ram.sv =====
// ----------------------------------------------------------------------------
// lruk_ram
// Simple dual-port key store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lruk_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/lru_k_replacement_policy_unit_tb.sv =====
// ----------------------------------------------------------------------------
// lru_k_replacement_policy_unit_tb
// Self-checking testbench for the LRU-K replacement policy unit. It sends
// access requests, mirrors the history FIFO and the LRU cache in its own
// model, and compares every result field by field with the expected outcome.
// ----------------------------------------------------------------------------
module lru_k_replacement_policy_unit_tb
  import lruk_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_N  = HIST_DEPTH_DEF;
  localparam int CACHE_N = CACHE_DEPTH_DEF;

  // A register index past the last one. Writes to it must change nothing.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // The slowest request walks the cache once and the history twice.
  localparam int SETTLE_CYCLES = 4 * (CACHE_N + 2 * HIST_N + 4);
  localparam int CYCLE_LIMIT   = 1_000_000;

  // Patterns that the result receiver cycles through.
  typedef enum int {
    RDY_ALWAYS,
    RDY_HALF,
    RDY_MOSTLY,
    RDY_SLOW
  } ready_mode_e;

  // One expected result of an access request.
  typedef struct {
    logic                  hit;
    logic                  promoted;
    logic                  evict_valid;
    logic [PORT_KEY_W-1:0] evict_key;
    logic                  drop_valid;
    logic [PORT_KEY_W-1:0] drop_key;
  } access_outcome_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  access_valid_i;
  logic                  access_ready_o;
  logic [PORT_KEY_W-1:0] access_key_i;
  logic                  result_valid_o;
  logic                  result_ready_i;
  logic                  hit_o;
  logic                  promoted_o;
  logic                  cache_evict_valid_o;
  logic [PORT_KEY_W-1:0] cache_evict_key_o;
  logic                  history_drop_valid_o;
  logic [PORT_KEY_W-1:0] history_drop_key_o;

  // Outcomes of accepted requests whose results have not come back yet.
  access_outcome_t outcome_q[$];
  int              err_count = 0;
  int              cycle_count = 0;

  // Mirror of the configuration registers, holding the written values cut to the field widths.
  int k_cfg;
  int hlim_cfg;
  int clim_cfg;

  // Mirror of the history FIFO (index 0 is oldest) and of the LRU cache.
  logic [PORT_KEY_W-1:0] hist_keys[HIST_N];
  int                    hist_fill;
  logic [PORT_KEY_W-1:0] lru_keys[CACHE_N];
  bit                    lru_used[CACHE_N];
  int                    lru_age[CACHE_N];

  // Keys that the random traffic draws from, so that repeats are common.
  logic [PORT_KEY_W-1:0] key_pool[16];

  lru_k_replacement_policy_unit u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .access_valid_i      (access_valid_i),
    .access_ready_o      (access_ready_o),
    .access_key_i        (access_key_i),
    .result_valid_o      (result_valid_o),
    .result_ready_i      (result_ready_i),
    .hit_o               (hit_o),
    .promoted_o          (promoted_o),
    .cache_evict_valid_o (cache_evict_valid_o),
    .cache_evict_key_o   (cache_evict_key_o),
    .history_drop_valid_o(history_drop_valid_o),
    .history_drop_key_o  (history_drop_key_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Puts the mirror back into its post-reset state.
  function automatic void clear_policy_state();
    k_cfg     = int'(KTH_RST);
    hlim_cfg  = int'(HLIM_RST);
    clim_cfg  = int'(CLIM_RST);
    hist_fill = 0;
    for (int i = 0; i < CACHE_N; i++) begin
      lru_used[i] = 1'b0;
      lru_age[i]  = 0;
    end
  endfunction

  // Applies one access to the mirror and returns the result it must cause.
  // Age 0 is the most recent cache entry; the valid entries hold distinct ages.
  function automatic access_outcome_t apply_access(input logic [PORT_KEY_W-1:0] key);
    access_outcome_t res;
    int slot;
    int rank;
    int seen;
    int need;
    int wr;
    int room;
    int occupied;
    int oldest;
    res = '{default: '0};
    slot = -1;
    for (int i = 0; i < CACHE_N; i++) begin
      if (slot < 0 && lru_used[i] && lru_keys[i] == key) slot = i;
    end
    if (slot >= 0) begin
      // Hit: everything more recent than this entry ages by one.
      rank = lru_age[slot];
      for (int j = 0; j < CACHE_N; j++) begin
        if (lru_used[j] && lru_age[j] < rank) lru_age[j]++;
      end
      lru_age[slot] = 0;
      res.hit = 1'b1;
    end else begin
      // A threshold below two behaves as two.
      need = (k_cfg < 2) ? 2 : k_cfg;
      seen = 0;
      for (int i = 0; i < hist_fill; i++) begin
        if (hist_keys[i] == key) seen++;
      end
      // At least, not exactly: the threshold may have been lowered meanwhile.
      if (seen >= 1 && seen + 1 >= need) begin
        wr = 0;
        for (int i = 0; i < hist_fill; i++) begin
          if (hist_keys[i] != key) begin
            hist_keys[wr] = hist_keys[i];
            wr++;
          end
        end
        hist_fill = wr;
        room = (clim_cfg < 1) ? 1 : ((clim_cfg > CACHE_N) ? CACHE_N : clim_cfg);
        occupied = 0;
        for (int j = 0; j < CACHE_N; j++) begin
          if (lru_used[j]) occupied++;
        end
        // A shrunken limit may force several evictions; only the first is reported.
        while (occupied >= room) begin
          oldest = -1;
          for (int j = 0; j < CACHE_N; j++) begin
            if (lru_used[j] && (oldest < 0 || lru_age[j] > lru_age[oldest])) oldest = j;
          end
          lru_used[oldest] = 1'b0;
          occupied--;
          if (!res.evict_valid) begin
            res.evict_valid = 1'b1;
            res.evict_key   = lru_keys[oldest];
          end
        end
        slot = -1;
        for (int j = 0; j < CACHE_N; j++) begin
          if (lru_used[j]) lru_age[j]++;
          else if (slot < 0) slot = j;
        end
        lru_keys[slot] = key;
        lru_used[slot] = 1'b1;
        lru_age[slot]  = 0;
        res.promoted   = 1'b1;
      end else begin
        room = (hlim_cfg < 1) ? 1 : ((hlim_cfg > HIST_N) ? HIST_N : hlim_cfg);
        while (hist_fill >= room) begin
          if (!res.drop_valid) begin
            res.drop_valid = 1'b1;
            res.drop_key   = hist_keys[0];
          end
          for (int i = 1; i < hist_fill; i++) hist_keys[i-1] = hist_keys[i];
          hist_fill--;
        end
        hist_keys[hist_fill] = key;
        hist_fill++;
      end
    end
    return res;
  endfunction

  // Most keys come from the pool; one in eight is a fresh random pattern.
  function automatic logic [PORT_KEY_W-1:0] pick_key(input int pool_n);
    if ($urandom_range(0, 7) == 0) return $urandom;
    return key_pool[$urandom_range(0, pool_n - 1)];
  endfunction

  // Called at a falling edge. Leaves valid high on return so that the next
  // request can follow without a bubble; callers lower it for a gap.
  task automatic send_access(input logic [PORT_KEY_W-1:0] key);
    access_valid_i <= 1'b1;
    access_key_i   <= key;
    @(posedge clk_i);
    while (!access_ready_o) @(posedge clk_i);
    outcome_q.insert(outcome_q.size(), apply_access(key));
    @(negedge clk_i);
  endtask

  // Holds the sender off until every outstanding result has come back, then
  // gives the block time to finish any internal bookkeeping.
  task automatic wait_results_drained();
    access_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Two-phase register write, issued only while the block is idle.
  task automatic write_reg(input logic [1:0] idx, input int value);
    wait_results_drained();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_K_THRESHOLD:   k_cfg    = value & 'hF;
      REG_HISTORY_LIMIT: hlim_cfg = value & 'h1F;
      REG_CACHE_LIMIT:   clim_cfg = value & 'hF;
      default: ;
    endcase
  endtask

  task automatic compare_field(input string fname, input logic [PORT_KEY_W-1:0] want,
                               input logic [PORT_KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, want, got);
      err_count++;
    end
  endtask

  // Result checker: every accepted result is matched against the oldest
  // outstanding request.
  always @(posedge clk_i) begin
    access_outcome_t want;
    if (rst_ni && result_valid_o && result_ready_i) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: result with no request outstanding: expected none, actual hit=%b",
                 $time, hit_o);
        err_count++;
      end else begin
        want = outcome_q[0];
        outcome_q.delete(0);
        compare_field("hit", PORT_KEY_W'(want.hit), PORT_KEY_W'(hit_o));
        compare_field("promoted", PORT_KEY_W'(want.promoted), PORT_KEY_W'(promoted_o));
        compare_field("cache_evict_valid", PORT_KEY_W'(want.evict_valid),
                      PORT_KEY_W'(cache_evict_valid_o));
        compare_field("cache_evict_key", want.evict_key, cache_evict_key_o);
        compare_field("history_drop_valid", PORT_KEY_W'(want.drop_valid),
                      PORT_KEY_W'(history_drop_valid_o));
        compare_field("history_drop_key", want.drop_key, history_drop_key_o);
      end
    end
  end

  // Watchdog. The limit is several times the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lru_k_replacement_policy_unit_tb: done, errors");
      $finish;
    end
  end

  // Result receiver. It switches between always ready, coin-flip stalls,
  // rare stalls and long stalls, each held for a random stretch of cycles.
  initial begin
    ready_mode_e mode;
    int span;
    result_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = ready_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          RDY_ALWAYS: result_ready_i <= 1'b1;
          RDY_HALF:   result_ready_i <= ($urandom_range(0, 1) == 1);
          RDY_MOSTLY: result_ready_i <= ($urandom_range(0, 7) != 0);
          default:    result_ready_i <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  // With the reset configuration (K of two), a key's second request promotes
  // it and the third one hits. The all-zero and all-one keys are used.
  task automatic test_default_config();
    repeat (3) send_access('0);
    repeat (3) send_access('1);
  endtask

  // Thresholds of zero and one behave like two.
  task automatic test_threshold_floor();
    write_reg(REG_K_THRESHOLD, 0);
    repeat (2) send_access(32'hA5A5_0001);
    write_reg(REG_K_THRESHOLD, 1);
    repeat (2) send_access(32'h5A5A_0002);
  endtask

  // Three requests land in the history under a K of six. After K drops to
  // two, the next request finds a count above the threshold and promotes.
  task automatic test_threshold_lowered();
    write_reg(REG_K_THRESHOLD, 6);
    repeat (3) send_access(32'hC3C3_0003);
    write_reg(REG_K_THRESHOLD, 2);
    send_access(32'hC3C3_0003);
  endtask

  // A write past the last register must not alter the cache limit; a
  // promotion into a cache with free room then evicts nothing.
  task automatic test_unused_register();
    write_reg(REG_UNUSED, 1);
    repeat (2) send_access(32'h1234_5678);
  endtask

  // A cache limit of zero acts as one. The cache holds six keys here, so
  // the promotion evicts all of them and reports only the least recent.
  task automatic test_cache_shrink();
    write_reg(REG_CACHE_LIMIT, 0);
    repeat (2) send_access(32'h0F0F_0004);
    write_reg(REG_CACHE_LIMIT, 15);
  endtask

  // A history limit of 31 acts as the full depth. A limit of zero acts as
  // one, so the next miss drops three entries and reports the oldest.
  task automatic test_history_limits();
    write_reg(REG_HISTORY_LIMIT, 31);
    send_access(32'h8000_0001);
    send_access(32'h4000_0002);
    send_access(32'h2000_0003);
    write_reg(REG_HISTORY_LIMIT, 0);
    send_access(32'h1000_0004);
    send_access(32'h0800_0005);
    write_reg(REG_HISTORY_LIMIT, 16);
  endtask

  // Random traffic under one configuration. The sender alternates bursts
  // and gaps and, at one random point, waits for every result to come back.
  task automatic run_random_phase(input int kth, input int hlim, input int clim,
                                  input int count, input int pool_n);
    int burst_left;
    int gap;
    int drain_at;
    write_reg(REG_K_THRESHOLD, kth);
    write_reg(REG_HISTORY_LIMIT, hlim);
    write_reg(REG_CACHE_LIMIT, clim);
    for (int i = 0; i < pool_n; i++) key_pool[i] = $urandom;
    burst_left = 0;
    drain_at   = $urandom_range(count / 4, 3 * count / 4);
    for (int n = 0; n < count; n++) begin
      if (n == drain_at) wait_results_drained();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          access_valid_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      send_access(pick_key(pool_n));
      burst_left--;
    end
    access_valid_i <= 1'b0;
  endtask

  task automatic test_random_default();
    run_random_phase(2, 16, 8, 300, 12);
  endtask

  // A large K of eight with few keys, so that promotions still happen.
  task automatic test_random_deep_threshold();
    run_random_phase(8, 16, 8, 250, 3);
  endtask

  task automatic test_random_small_limits();
    run_random_phase(3, 4, 2, 250, 6);
  endtask

  // One history slot and one cache slot: drops and evictions on most misses.
  task automatic test_random_single_entry();
    run_random_phase(2, 1, 1, 200, 4);
  endtask

  // Any value that the register fields can hold, clamped ones included.
  // Limits often shrink below the current occupancy between phases.
  task automatic test_random_config_sweep();
    repeat (4) begin
      run_random_phase($urandom_range(0, 15), $urandom_range(0, 31),
                       $urandom_range(0, 15), 150, $urandom_range(2, 10));
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    access_valid_i = 1'b0;
    access_key_i   = '0;
    clear_policy_state();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_default_config();
    test_threshold_floor();
    test_threshold_lowered();
    test_unused_register();
    test_cache_shrink();
    test_history_limits();
    test_random_default();
    test_random_deep_threshold();
    test_random_small_limits();
    test_random_single_entry();
    test_random_config_sweep();

    wait_results_drained();
    if (err_count == 0) begin
      $display("lru_k_replacement_policy_unit_tb: done, clean");
    end else begin
      $display("lru_k_replacement_policy_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
